>>> sv/cgr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cgr_pkg
// Shared sizes, codes and command/status bundles of the color gradient ramp.
// ----------------------------------------------------------------------------
package cgr_pkg;

   // table depth and derived widths
   localparam int MAX_POINTS = 16;
   localparam int IDX_W      = $clog2(MAX_POINTS);
   localparam int CNT_W      = $clog2(MAX_POINTS + 1);

   // fixed field widths
   localparam int VAL_W  = 16;
   localparam int PT_W   = 5;
   localparam int W_W    = VAL_W + 1;          // weight 0..65536
   localparam int DIFF_W = VAL_W + 1;          // signed channel difference
   localparam int PROD_W = DIFF_W + W_W + 1;   // signed product
   localparam int STEP_W = $clog2(VAL_W);

   localparam logic [W_W-1:0]    W_ONE    = W_W'(1 << VAL_W);
   localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(1 << (VAL_W - 1));

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_QUERY  = 2'd1,
      OP_CLEAR  = 2'd2
   } opcode_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_FEW   = 2'd2,
      ST_NOSEG = 2'd3
   } status_type;

   // one stored control point
   typedef struct packed {
      logic [VAL_W-1:0] pos;
      logic [VAL_W-1:0] red;
      logic [VAL_W-1:0] green;
      logic [VAL_W-1:0] blue;
   } entry_type;

   // controller to datapath
   typedef struct packed {
      logic       load_req;
      logic       cnt_clear;
      logic       cnt_inc;
      logic       idx_top;
      logic       idx_clear;
      logic       idx_inc;
      logic       idx_dec;
      logic       rd_below;
      logic       wr_en;
      logic       wr_new;
      logic       prev_load;
      logic       div_start;
      logic       div_step;
      logic       mul_en;
      logic       add_en;
      logic       rsp_load;
      status_type rsp_status;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      opcode_type opcode;
      logic       full;
      logic       few;
      logic       idx_zero;
      logic       idx_last;
      logic       less;
      logic       hit;
      logic       div_last;
      logic       ch_last;
   } stat_type;

endpackage

>>> sv/cgr_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cgr_req_if / cgr_rsp_if
// Valid/ready channels for operation requests and their results.
// ----------------------------------------------------------------------------
interface cgr_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  opcode;
   logic [15:0] position;
   logic [15:0] in_red;
   logic [15:0] in_green;
   logic [15:0] in_blue;

   modport source (output valid, output opcode, output position, output in_red,
                   output in_green, output in_blue, input ready);
   modport sink   (input valid, input opcode, input position, input in_red,
                   input in_green, input in_blue, output ready);
endinterface

interface cgr_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] out_red;
   logic [15:0] out_green;
   logic [15:0] out_blue;
   logic [1:0]  status;
   logic [4:0]  point_total;

   modport source (output valid, output out_red, output out_green, output out_blue,
                   output status, output point_total, input ready);
   modport sink   (input valid, input out_red, input out_green, input out_blue,
                   input status, input point_total, output ready);
endinterface

>>> sv/cgr_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cgr_dpath
// Point table, scan registers, radix-2 weight divider and channel blender.
// ----------------------------------------------------------------------------
module cgr_dpath (
   input  logic                         clock,
   input  logic                         reset,
   input  cgr_pkg::cmd_type             cmd,
   output cgr_pkg::stat_type            stat,
   input  logic [1:0]                   req_opcode,
   input  logic [cgr_pkg::VAL_W-1:0]    req_position,
   input  logic [cgr_pkg::VAL_W-1:0]    req_red,
   input  logic [cgr_pkg::VAL_W-1:0]    req_green,
   input  logic [cgr_pkg::VAL_W-1:0]    req_blue,
   output logic [cgr_pkg::VAL_W-1:0]    rsp_red,
   output logic [cgr_pkg::VAL_W-1:0]    rsp_green,
   output logic [cgr_pkg::VAL_W-1:0]    rsp_blue,
   output logic [1:0]                   rsp_status,
   output logic [cgr_pkg::PT_W-1:0]     rsp_total
);

   // captured request
   cgr_pkg::opcode_type         op_ff;
   cgr_pkg::entry_type          new_ff;

   // table
   cgr_pkg::entry_type          mem [cgr_pkg::MAX_POINTS];
   cgr_pkg::entry_type          rd_data_ff;
   logic [cgr_pkg::IDX_W-1:0]   rd_addr;
   logic [cgr_pkg::CNT_W-1:0]   count_ff;
   logic [cgr_pkg::CNT_W-1:0]   idx_ff;
   logic [cgr_pkg::CNT_W-1:0]   idx_m1;

   // segment and divider
   cgr_pkg::entry_type          prev_ff;
   cgr_pkg::entry_type          cur_ff;
   logic [cgr_pkg::VAL_W-1:0]   span_ff;
   logic [cgr_pkg::VAL_W-1:0]   rem_ff;
   logic [cgr_pkg::VAL_W-1:0]   quo_ff;
   logic [cgr_pkg::STEP_W-1:0]  step_ff;
   logic                        w_zero_ff;
   logic                        w_full_ff;
   logic [cgr_pkg::VAL_W-1:0]   pos_ofs;
   logic [cgr_pkg::VAL_W-1:0]   span;
   logic [cgr_pkg::VAL_W:0]     rem_sh;
   logic                        rem_ge;
   logic [cgr_pkg::W_W-1:0]     weight;

   // blender
   logic [1:0]                        ch_ff;
   logic [cgr_pkg::VAL_W-1:0]         c0_sel;
   logic [cgr_pkg::VAL_W-1:0]         c1_sel;
   logic signed [cgr_pkg::DIFF_W-1:0] diff;
   logic signed [cgr_pkg::PROD_W-1:0] prod_in;
   logic signed [cgr_pkg::PROD_W-1:0] prod_ff;
   logic signed [cgr_pkg::PROD_W-1:0] acc;
   logic [cgr_pkg::VAL_W-1:0]         res_r_ff;
   logic [cgr_pkg::VAL_W-1:0]         res_g_ff;
   logic [cgr_pkg::VAL_W-1:0]         res_b_ff;

   // addresses
   assign idx_m1  = idx_ff - cgr_pkg::CNT_W'(1);
   assign rd_addr = cmd.rd_below ? idx_m1[cgr_pkg::IDX_W-1:0]
                                 : idx_ff[cgr_pkg::IDX_W-1:0];

   // request capture
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         op_ff        <= cgr_pkg::opcode_type'(req_opcode);
         new_ff.pos   <= req_position;
         new_ff.red   <= req_red;
         new_ff.green <= req_green;
         new_ff.blue  <= req_blue;
      end
   end

   // table memory, one write and one registered read port
   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[idx_ff[cgr_pkg::IDX_W-1:0]] <= cmd.wr_new ? new_ff : rd_data_ff;
      end
      rd_data_ff <= mem[rd_addr];
   end

   // point count and scan index
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         idx_ff   <= '0;
      end else begin
         if (cmd.cnt_clear) begin
            count_ff <= '0;
         end else if (cmd.cnt_inc) begin
            count_ff <= count_ff + cgr_pkg::CNT_W'(1);
         end
         if (cmd.idx_top) begin
            idx_ff <= count_ff;
         end else if (cmd.idx_clear) begin
            idx_ff <= '0;
         end else if (cmd.idx_inc) begin
            idx_ff <= idx_ff + cgr_pkg::CNT_W'(1);
         end else if (cmd.idx_dec) begin
            idx_ff <= idx_m1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.prev_load) begin
         prev_ff <= rd_data_ff;
      end
   end

   // weight divider: one quotient bit per step
   assign pos_ofs = new_ff.pos - prev_ff.pos;
   assign span    = rd_data_ff.pos - prev_ff.pos;
   assign rem_sh  = {rem_ff, 1'b0};
   assign rem_ge  = rem_sh >= {1'b0, span_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
      end else if (cmd.div_start) begin
         step_ff <= '0;
      end else if (cmd.div_step) begin
         step_ff <= step_ff + cgr_pkg::STEP_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         cur_ff    <= rd_data_ff;
         span_ff   <= span;
         rem_ff    <= pos_ofs;
         quo_ff    <= '0;
         w_zero_ff <= (span == '0);
         w_full_ff <= (pos_ofs == span);
      end else if (cmd.div_step) begin
         rem_ff <= rem_ge ? cgr_pkg::VAL_W'(rem_sh - {1'b0, span_ff})
                          : rem_sh[cgr_pkg::VAL_W-1:0];
         quo_ff <= {quo_ff[cgr_pkg::VAL_W-2:0], rem_ge};
      end
   end

   // zero span gives weight zero; a position on the upper end gives full weight
   always_comb begin
      if (w_zero_ff) begin
         weight = '0;
      end else if (w_full_ff) begin
         weight = cgr_pkg::W_ONE;
      end else begin
         weight = {1'b0, quo_ff};
      end
   end

   // channel select for the shared multiplier
   always_comb begin
      case (ch_ff)
         2'd0: begin
            c0_sel = prev_ff.red;
            c1_sel = cur_ff.red;
         end
         2'd1: begin
            c0_sel = prev_ff.green;
            c1_sel = cur_ff.green;
         end
         default: begin
            c0_sel = prev_ff.blue;
            c1_sel = cur_ff.blue;
         end
      endcase
   end

   // c0 + ((c1 - c0) * w + half) >> 16
   assign diff    = $signed({1'b0, c1_sel}) - $signed({1'b0, c0_sel});
   assign prod_in = diff * $signed({1'b0, weight});
   assign acc     = $signed({{(cgr_pkg::PROD_W-2*cgr_pkg::VAL_W){1'b0}}, c0_sel,
                             {cgr_pkg::VAL_W{1'b0}}})
                    + prod_ff + $signed(cgr_pkg::ROUND_HALF);

   always_ff @(posedge clock) begin
      if (reset) begin
         ch_ff <= '0;
      end else if (cmd.div_start) begin
         ch_ff <= '0;
      end else if (cmd.add_en) begin
         ch_ff <= ch_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.mul_en) begin
         prod_ff <= prod_in;
      end
   end

   // interpolated color, black unless a query finishes its blend
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         res_r_ff <= '0;
         res_g_ff <= '0;
         res_b_ff <= '0;
      end else if (cmd.add_en) begin
         case (ch_ff)
            2'd0:    res_r_ff <= acc[2*cgr_pkg::VAL_W-1:cgr_pkg::VAL_W];
            2'd1:    res_g_ff <= acc[2*cgr_pkg::VAL_W-1:cgr_pkg::VAL_W];
            default: res_b_ff <= acc[2*cgr_pkg::VAL_W-1:cgr_pkg::VAL_W];
         endcase
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_red    <= res_r_ff;
         rsp_green  <= res_g_ff;
         rsp_blue   <= res_b_ff;
         rsp_status <= cmd.rsp_status;
         rsp_total  <= cgr_pkg::PT_W'(count_ff);
      end
   end

   // status to the controller
   always_comb begin
      stat.opcode   = op_ff;
      stat.full     = count_ff >= cgr_pkg::CNT_W'(cgr_pkg::MAX_POINTS);
      stat.few      = count_ff < cgr_pkg::CNT_W'(2);
      stat.idx_zero = idx_ff == '0;
      stat.idx_last = (idx_ff + cgr_pkg::CNT_W'(1)) == count_ff;
      stat.less     = new_ff.pos < rd_data_ff.pos;
      stat.hit      = (new_ff.pos >= prev_ff.pos) && (new_ff.pos <= rd_data_ff.pos);
      stat.div_last = step_ff == cgr_pkg::STEP_W'(cgr_pkg::VAL_W - 1);
      stat.ch_last  = ch_ff == 2'd2;
   end

endmodule

>>> sv/cgr_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cgr_ctrl
// Sequencer for insert, query and clear; owns the handshake flags.
// ----------------------------------------------------------------------------
module cgr_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   input  cgr_pkg::stat_type  stat,
   output cgr_pkg::cmd_type   cmd
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_INS_CHK,
      S_INS_EV,
      S_Q_RD,
      S_Q_EV,
      S_DIV,
      S_MUL,
      S_ADD,
      S_RESP
   } state_type;

   state_type            state_ff, state_in;
   cgr_pkg::status_type  code_ff, code_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // next state and commands
   always_comb begin
      state_in       = state_ff;
      code_in        = code_ff;
      cmd            = '0;
      cmd.rsp_status = code_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               code_in      = cgr_pkg::ST_OK;
               state_in     = S_DECODE;
            end
         end
         S_DECODE: begin
            case (stat.opcode)
               cgr_pkg::OP_INSERT: begin
                  if (stat.full) begin
                     code_in  = cgr_pkg::ST_FULL;
                     state_in = S_RESP;
                  end else begin
                     cmd.idx_top = 1'b1;
                     state_in    = S_INS_CHK;
                  end
               end
               cgr_pkg::OP_QUERY: begin
                  if (stat.few) begin
                     code_in  = cgr_pkg::ST_FEW;
                     state_in = S_RESP;
                  end else begin
                     cmd.idx_clear = 1'b1;
                     state_in      = S_Q_RD;
                  end
               end
               cgr_pkg::OP_CLEAR: begin
                  cmd.cnt_clear = 1'b1;
                  state_in      = S_RESP;
               end
               default: begin
                  state_in = S_RESP;
               end
            endcase
         end
         // walk down from the top, moving larger entries up one slot
         S_INS_CHK: begin
            cmd.rd_below = 1'b1;
            if (stat.idx_zero) begin
               cmd.wr_en   = 1'b1;
               cmd.wr_new  = 1'b1;
               cmd.cnt_inc = 1'b1;
               state_in    = S_RESP;
            end else begin
               state_in = S_INS_EV;
            end
         end
         S_INS_EV: begin
            cmd.rd_below = 1'b1;
            cmd.wr_en    = 1'b1;
            if (stat.less) begin
               cmd.idx_dec = 1'b1;
               state_in    = S_INS_CHK;
            end else begin
               cmd.wr_new  = 1'b1;
               cmd.cnt_inc = 1'b1;
               state_in    = S_RESP;
            end
         end
         // segment scan, lower end held in the previous-point register
         S_Q_RD: begin
            state_in = S_Q_EV;
         end
         S_Q_EV: begin
            if (stat.idx_zero) begin
               cmd.prev_load = 1'b1;
               cmd.idx_inc   = 1'b1;
               state_in      = S_Q_RD;
            end else if (stat.hit) begin
               cmd.div_start = 1'b1;
               state_in      = S_DIV;
            end else if (stat.idx_last) begin
               code_in  = cgr_pkg::ST_NOSEG;
               state_in = S_RESP;
            end else begin
               cmd.prev_load = 1'b1;
               cmd.idx_inc   = 1'b1;
               state_in      = S_Q_RD;
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (stat.div_last) begin
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            cmd.mul_en = 1'b1;
            state_in   = S_ADD;
         end
         S_ADD: begin
            cmd.add_en = 1'b1;
            state_in   = stat.ch_last ? S_RESP : S_MUL;
         end
         S_RESP: begin
            if (slot_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // result valid flag
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         code_ff      <= cgr_pkg::ST_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         code_ff      <= code_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

>>> sv/color_gradient_ramp_lookup.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// color_gradient_ramp_lookup
// Sorted table of color control points with piecewise linear lookup.
// ----------------------------------------------------------------------------
// One operation is in flight at a time; the next request is taken once the
// result of the current one sits in the output register. A clear, an unused
// opcode or a refused insert goes from decode straight to the result. An
// insert moves each stored point above the new one up one slot, each move
// being a read and then a write through the table's read and write ports. A
// query scans the points one at a time through the read port, then runs the
// bit-per-cycle weight divider and blends the three channels in turn through
// the shared multiplier. The table is not cleared after reset; only entries
// below the point count are ever read.
module color_gradient_ramp_lookup (
   input  logic        clock,
   input  logic        reset,
   cgr_req_if.sink     req_ch,
   cgr_rsp_if.source   rsp_ch
);

   cgr_pkg::cmd_type  cmd;
   cgr_pkg::stat_type stat;

   cgr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   cgr_dpath u_dpath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .stat         (stat),
      .req_opcode   (req_ch.opcode),
      .req_position (req_ch.position),
      .req_red      (req_ch.in_red),
      .req_green    (req_ch.in_green),
      .req_blue     (req_ch.in_blue),
      .rsp_red      (rsp_ch.out_red),
      .rsp_green    (rsp_ch.out_green),
      .rsp_blue     (rsp_ch.out_blue),
      .rsp_status   (rsp_ch.status),
      .rsp_total    (rsp_ch.point_total)
   );

   // one operation at a time: no new transfer right after one is taken
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> !req_ch.ready)
      else $error("request taken while an operation is in flight");

   // only a successful query carries a color
   a_black_on_error: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.status != cgr_pkg::ST_OK) |->
      (rsp_ch.out_red == '0 && rsp_ch.out_green == '0 && rsp_ch.out_blue == '0))
      else $error("non-black color on an error result");

   // a refused insert reports a full table
   a_full_total: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.status == cgr_pkg::ST_FULL) |->
      (rsp_ch.point_total == cgr_pkg::PT_W'(cgr_pkg::MAX_POINTS)))
      else $error("table full reported with wrong point total");

   // too few points really means fewer than two
   a_few_total: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.status == cgr_pkg::ST_FEW) |->
      (rsp_ch.point_total < cgr_pkg::PT_W'(2)))
      else $error("too-few-points status with two or more points");

endmodule
